FILE: design/lrt_pkg.sv
// Shared types, codes and defaults of the logistic-regression trainer.
// Used by the cell row, the sigmoid table and the top level; depends on nothing.
`default_nettype none

package lrt_pkg;

    localparam int MAX_FEATURES_DEF = 16;
    localparam int SIG_DEPTH_DEF    = 1024;

    localparam logic [1:0] REG_FEATURE_COUNT = 2'd0;
    localparam logic [1:0] REG_BATCH_SIZE    = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE     = 2'd2;

    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_EVAL,
        ST_SIG,
        ST_ROM,
        ST_LAUNCH,
        ST_GRAD,
        ST_UMUL,
        ST_UABS,
        ST_UDIV,
        ST_UWR
    } t_state;

    typedef struct packed {
        logic               vld;
        logic signed [16:0] c;
    } t_tok;

    typedef struct packed {
        logic               x_we;
        logic [5:0]         x_sel;
        logic signed [15:0] x_val;
        logic               w_we;
        logic [5:0]         w_sel;
        logic signed [31:0] w_val;
        logic [5:0]         fcnt;
    } t_ctl;

endpackage

`default_nettype wire

FILE: design/lrt_cell.sv
// One cell of the weight row: a weight, its gradient sum and one buffered feature.
// Passes the gradient coefficient on to its neighbour; uses lrt_pkg.
`default_nettype none

module lrt_cell
    import lrt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctl               i_ctl,
    input  wire t_tok               i_tok,
    output t_tok                    o_tok,
    output logic signed [31:0]      o_w,
    output logic signed [47:0]      o_g
);

    logic signed [31:0] r_w;
    logic signed [47:0] r_g;
    logic signed [15:0] r_x;
    t_tok               r_tok;
    logic signed [15:0] xv;
    logic signed [32:0] term;
    logic signed [48:0] sum;
    logic signed [47:0] sat;

    assign xv   = (IDX == 0) ? 16'sd4096 : r_x;
    assign term = i_tok.c * xv;
    assign sum  = 49'(r_g) + 49'(term);

    always_comb begin
        if (sum > 49'sh0_7FFF_FFFF_FFFF) begin
            sat = 48'sh7FFF_FFFF_FFFF;
        end else if (sum < -49'sh0_8000_0000_0000) begin
            sat = 48'sh8000_0000_0000;
        end else begin
            sat = sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.x_we && i_ctl.x_sel == 6'(IDX)) begin
            r_x <= i_ctl.x_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= '0;
            r_g   <= '0;
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_ctl.w_we && i_ctl.w_sel == 6'(IDX)) begin
                r_w <= i_ctl.w_val;
                r_g <= '0;
            end else if (i_tok.vld && 6'(IDX) <= i_ctl.fcnt) begin
                r_g <= sat;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_w   = r_w;
    assign o_g   = r_g;

endmodule

`default_nettype wire

FILE: design/lrt_sig_rom.sv
// Sigmoid lookup table in Q0.16, built at elaboration, read through a register.
// Uses lrt_pkg for its default depth.
`default_nettype none

module lrt_sig_rom
    import lrt_pkg::*;
#(
    parameter int DEPTH = SIG_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    output logic [15:0]                   o_data
);

    typedef logic [15:0] t_rom [DEPTH];

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = n;
        for (int i = 0; i < 64; i++) begin
            rem = {rem[63:0], q[63]};
            q   = {q[62:0], 1'b0};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_rom build();
        t_rom        tab;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] eh;
        logic [63:0] den;
        int          lo;
        int          hi;
        for (int i = 0; i < DEPTH; i++) begin
            tab[i] = '0;
        end
        h    = udiv(64'd8 << 32, 64'(DEPTH));
        term = 64'd1 << 32;
        sum  = 64'd1 << 32;
        for (int k = 1; k <= 12; k++) begin
            term = udiv((term * h) >> 32, 64'(k));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        eh = sum;
        e  = 64'd1 << 32;
        for (int m = 0; m <= DEPTH; m++) begin
            if ((DEPTH - m) % 2 == 0) begin
                den = (64'd1 << 32) + e;
                lo  = (DEPTH - m) / 2;
                hi  = (DEPTH + m) / 2;
                tab[lo] = 16'(udiv((e << 16) + (den >> 1), den));
                if (hi < DEPTH) begin
                    tab[hi] = 16'(udiv((64'd1 << 48) + (den >> 1), den));
                end
            end
            e = (e * eh + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_rom ROM = build();

    logic [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: design/logistic_regression_sgd_trainer.sv
// Top level of the logistic-regression minibatch trainer: control, score path,
// shared update divider and the row of lrt_cell; uses lrt_pkg and lrt_sig_rom.
//
//  channel  | direction | beat content
//  s_axis   | in        | tuser op, tdata feature_value and label_bit
//  m_axis   | out       | tuser kind, tdata index, weight and verdict, tlast
//  apb      | in/out    | feature_count, batch_size, step size at 0, 4, 8
//
// Each element passes through the weight multiplier and then the score adder.
// A train sample end adds the table read and the coefficient running down the
// cell row; an evaluate sample end adds the verdict beat.
// A minibatch end passes each weight in turn through the one-bit divider.
// Reset is synchronous; output stalls hold the result register and the update pass.
`default_nettype none

module logistic_regression_sgd_trainer
    import lrt_pkg::*;
#(
    parameter int MAX_FEATURES        = MAX_FEATURES_DEF,
    parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // feature_value[15:0], label_bit[16], zero
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // weight_index[4:0], weight_value[36:5],
                                             // correct[37], zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(MAX_FEATURES + 1);
    localparam int AW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int DW = $clog2(SIGMOID_TABLE_DEPTH + 1);

    t_state r_state, n_state;

    logic [4:0]  r_fcnt;
    logic [6:0]  r_bsz;
    logic [15:0] r_lr;

    logic [CW-1:0]      r_elem, r_e, r_j;
    logic [6:0]         r_samp;
    logic signed [15:0] r_x;
    logic               r_op, r_lab;
    logic signed [47:0] r_prod, r_acc;
    logic [AW-1:0]      r_idx;
    logic signed [63:0] r_p;
    logic               r_neg;
    logic [47:0]        r_quo;
    logic [6:0]         r_rem;
    logic [5:0]         r_dcnt;

    logic               r_ovalid, r_ouser, r_olast;
    logic [39:0]        r_odata;

    logic [CW-1:0]      f_eff, e_cl, e_nxt;
    logic [6:0]         bs_eff;
    logic               accept, slot_free, o_load, launch, grad_done, more_elems;
    logic               w_we;
    logic signed [35:0] pd;
    logic signed [48:0] asum, u;
    logic [27:0]        uoff;
    logic [AW-1:0]      idx;
    logic [27+DW:0]     iprod;
    logic [15:0]        sig;
    logic signed [63:0] abs_p;
    logic [6:0]         rem2;
    logic signed [48:0] delta;
    logic signed [49:0] wdiff;
    logic signed [31:0] wnew;
    logic               correct;

    logic signed [31:0] w_arr [MAX_FEATURES+1];
    logic signed [47:0] g_arr [MAX_FEATURES+1];
    t_tok               tok [MAX_FEATURES+2];
    t_ctl               ctl;

    always_comb begin
        if (r_fcnt == 5'd0) begin
            f_eff = CW'(1);
        end else if (32'(r_fcnt) > MAX_FEATURES) begin
            f_eff = CW'(MAX_FEATURES);
        end else begin
            f_eff = CW'(r_fcnt);
        end
        if (r_bsz == 7'd0) begin
            bs_eff = 7'd1;
        end else if (r_bsz > 7'd64) begin
            bs_eff = 7'd64;
        end else begin
            bs_eff = r_bsz;
        end
        if (32'(r_elem) >= MAX_FEATURES) begin
            e_cl = CW'(MAX_FEATURES - 1);
        end else begin
            e_cl = r_elem;
        end
    end

    assign e_nxt      = CW'(r_e + 1'b1);
    assign more_elems = e_nxt < f_eff;
    assign slot_free  = !r_ovalid || m_axis_tready;
    assign grad_done  = tok[MAX_FEATURES+1].vld;

    assign pd   = 36'((r_prod + (r_prod < 0 ? 48'sd4095 : 48'sd0)) >>> 12);
    assign asum = 49'(r_acc) + 49'(pd);
    assign u    = r_lab ? -49'(r_acc) : 49'(r_acc);
    assign uoff = u[27:0] + 28'h800_0000;
    assign iprod = (28 + DW)'(uoff) * (28 + DW)'(SIGMOID_TABLE_DEPTH);

    always_comb begin
        if (u < -49'sd134217728) begin
            idx = '0;
        end else if (u >= 49'sd134217728) begin
            idx = AW'(SIGMOID_TABLE_DEPTH - 1);
        end else begin
            idx = iprod[28 +: AW];
        end
    end

    assign abs_p = r_p[63] ? -r_p : r_p;
    assign rem2  = {r_rem[5:0], r_quo[47]};
    assign delta = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign wdiff = 50'(w_arr[r_j]) - 50'(delta);

    always_comb begin
        if (wdiff > 50'sd2147483647) begin
            wnew = 32'sh7FFF_FFFF;
        end else if (wdiff < -50'sd2147483648) begin
            wnew = 32'sh8000_0000;
        end else begin
            wnew = wdiff[31:0];
        end
    end

    assign correct = r_lab ? (r_acc > 0) : (r_acc < 0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_MUL;
            ST_MUL:    n_state = ST_ACC;
            ST_ACC: begin
                if (more_elems) n_state = ST_IDLE;
                else if (r_op) n_state = ST_EVAL;
                else n_state = ST_SIG;
            end
            ST_EVAL:   if (slot_free) n_state = ST_IDLE;
            ST_SIG:    n_state = ST_ROM;
            ST_ROM:    n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_GRAD;
            ST_GRAD: begin
                if (grad_done) begin
                    if (r_samp + 7'd1 < bs_eff) n_state = ST_IDLE;
                    else n_state = ST_UMUL;
                end
            end
            ST_UMUL:   n_state = ST_UABS;
            ST_UABS:   n_state = ST_UDIV;
            ST_UDIV:   if (r_dcnt == 6'd47) n_state = ST_UWR;
            ST_UWR: begin
                if (slot_free) begin
                    if (r_j == f_eff) n_state = ST_IDLE;
                    else n_state = ST_UMUL;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        o_load        = 1'b0;
        launch        = 1'b0;
        w_we          = 1'b0;
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_EVAL:   o_load = slot_free;
            ST_LAUNCH: launch = 1'b1;
            ST_UWR: begin
                o_load = slot_free;
                w_we   = slot_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_elem   <= '0;
            r_samp   <= '0;
            r_ovalid <= 1'b0;
            r_fcnt   <= 5'd16;
            r_bsz    <= 7'd10;
            r_lr     <= 16'd4096;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_FEATURE_COUNT: r_fcnt <= pwdata[4:0];
                    REG_BATCH_SIZE:    r_bsz  <= pwdata[6:0];
                    REG_STEP_SIZE:     r_lr   <= pwdata[15:0];
                    default:           r_lr   <= r_lr;
                endcase
            end
            if (r_state == ST_ACC) begin
                r_elem <= more_elems ? e_nxt : '0;
            end
            if (r_state == ST_GRAD && grad_done) begin
                r_samp <= (r_samp + 7'd1 < bs_eff) ? r_samp + 7'd1 : 7'd0;
            end
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e   <= e_cl;
            r_x   <= $signed(s_axis_tdata[15:0]);
            r_lab <= s_axis_tdata[16];
            r_op  <= s_axis_tuser;
        end
        case (r_state)
            ST_MUL: begin
                r_prod <= 48'(w_arr[e_nxt] * r_x);
                if (r_e == '0) r_acc <= 48'(w_arr[0]);
            end
            ST_ACC: begin
                if (asum > 49'sh0_7FFF_FFFF_FFFF) r_acc <= 48'sh7FFF_FFFF_FFFF;
                else if (asum < -49'sh0_8000_0000_0000) r_acc <= 48'sh8000_0000_0000;
                else r_acc <= asum[47:0];
                r_j <= '0;
            end
            ST_SIG:  r_idx <= idx;
            ST_UMUL: r_p <= 64'(g_arr[r_j] * $signed({1'b0, r_lr}));
            ST_UABS: begin
                r_neg  <= r_p[63];
                r_quo  <= abs_p[63:16];
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            ST_UDIV: begin
                r_dcnt <= r_dcnt + 6'd1;
                if (rem2 >= bs_eff) begin
                    r_rem <= rem2 - bs_eff;
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
            end
            ST_UWR:  if (slot_free) r_j <= CW'(r_j + 1'b1);
            default: r_idx <= r_idx;
        endcase
        if (o_load) begin
            if (r_state == ST_EVAL) begin
                r_ouser <= KIND_VERDICT;
                r_olast <= 1'b1;
                r_odata <= {2'b00, correct, 32'd0, 5'd0};
            end else begin
                r_ouser <= KIND_WEIGHT;
                r_olast <= (r_j == f_eff);
                r_odata <= {3'b000, wnew, 5'(r_j)};
            end
        end
    end

    lrt_sig_rom #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (sig)
    );

    assign ctl.x_we  = accept;
    assign ctl.x_sel = 6'(e_cl + 1'b1);
    assign ctl.x_val = $signed(s_axis_tdata[15:0]);
    assign ctl.w_we  = w_we;
    assign ctl.w_sel = 6'(r_j);
    assign ctl.w_val = wnew;
    assign ctl.fcnt  = 6'(f_eff);

    assign tok[0].vld = launch;
    assign tok[0].c   = r_lab ? -$signed({1'b0, sig}) : $signed({1'b0, sig});

    for (genvar k = 0; k <= MAX_FEATURES; k++) begin : g_cell
        lrt_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1]),
            .o_w     (w_arr[k]),
            .o_g     (g_arr[k])
        );
    end

    always_comb begin
        case (paddr[3:2])
            REG_FEATURE_COUNT: prdata = {27'd0, r_fcnt};
            REG_BATCH_SIZE:    prdata = {25'd0, r_bsz};
            REG_STEP_SIZE:     prdata = {16'd0, r_lr};
            default:           prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

FILE: design/lrt_checker.sv
// Port-level checks on the trainer's result stream and configuration port,
// bound to logistic_regression_sgd_trainer; depends on nothing else.
`default_nettype none

module lrt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast,
    input wire logic        pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result beat changed.");

    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[36:0] == 37'd0)
        else $error("Verdict beat carries weight fields or lacks last.");

    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[37])
        else $error("Weight beat carries a verdict bit.");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("Result beat offered straight after reset.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("Configuration port not ready.");

endmodule

bind logistic_regression_sgd_trainer lrt_checker u_lrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

`default_nettype wire
